/* design/ssw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssw_pkg
// Shared types and constants for the two-wire seven-segment display writer.
// ----------------------------------------------------------------------------
package ssw_pkg;

   localparam int SEG_W    = 8;
   localparam int NUM_SEG  = 4;
   localparam int PIECE_W  = 4;
   localparam int PHASE_W  = 5;
   localparam int CSR_IX_W = 2;

   // opcodes
   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // register indices
   localparam logic [CSR_IX_W-1:0] CSR_DATA_CMD    = 2'd0;
   localparam logic [CSR_IX_W-1:0] CSR_ADDR_CMD    = 2'd1;
   localparam logic [CSR_IX_W-1:0] CSR_DISPLAY_CMD = 2'd2;
   localparam logic [CSR_IX_W-1:0] CSR_COLON_MASK  = 2'd3;

   // register reset values
   localparam logic [SEG_W-1:0] DATA_CMD_RST    = 8'h40;
   localparam logic [SEG_W-1:0] ADDR_CMD_RST    = 8'hC0;
   localparam logic [SEG_W-1:0] DISPLAY_CMD_RST = 8'h8F;
   localparam logic [SEG_W-1:0] COLON_MASK_RST  = 8'hFF;

   // piece kinds
   localparam logic [1:0] KIND_START = 2'd0;
   localparam logic [1:0] KIND_BYTE  = 2'd1;
   localparam logic [1:0] KIND_STOP  = 2'd2;

   // final tick phase of each piece kind
   localparam logic [PHASE_W-1:0] START_LAST = 5'd1;
   localparam logic [PHASE_W-1:0] STOP_LAST  = 5'd3;
   localparam logic [PHASE_W-1:0] BYTE_LAST  = 5'd29;

   typedef struct packed {
      logic [SEG_W-1:0] data_command;
      logic [SEG_W-1:0] address_command;
      logic [SEG_W-1:0] display_command;
      logic [SEG_W-1:0] colon_mask;
   } cfg_type;

   typedef struct packed {
      logic clock_level;
      logic data_level;
      logic frame_done;
      logic busy_res;
   } rsp_type;

   typedef logic [NUM_SEG-1:0][SEG_W-1:0] seg_array_type;

endpackage

/* design/ssw_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssw channel interfaces
// Valid/ready channels for requests, responses and register writes.
// ----------------------------------------------------------------------------
interface ssw_req_if;
   logic                     valid;
   logic                     ready;
   logic                     opcode;
   logic [ssw_pkg::SEG_W-1:0] segment_zero;
   logic [ssw_pkg::SEG_W-1:0] segment_one;
   logic [ssw_pkg::SEG_W-1:0] segment_two;
   logic [ssw_pkg::SEG_W-1:0] segment_three;

   modport source (output valid, opcode, segment_zero, segment_one, segment_two,
                   segment_three, input ready);
   modport sink   (input valid, opcode, segment_zero, segment_one, segment_two,
                   segment_three, output ready);
endinterface

interface ssw_rsp_if;
   logic valid;
   logic ready;
   logic clock_level;
   logic data_level;
   logic frame_done;
   logic busy_res;

   modport source (output valid, clock_level, data_level, frame_done, busy_res,
                   input ready);
   modport sink   (input valid, clock_level, data_level, frame_done, busy_res,
                   output ready);
endinterface

interface ssw_csr_if;
   logic                        valid;
   logic                        ready;
   logic [ssw_pkg::CSR_IX_W-1:0] index;
   logic [ssw_pkg::SEG_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* design/ssw_frame_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssw_frame_seq
// Frame sequencer: holds pin levels, piece/phase counters and the segment
// store, and advances the frame by one step on each tick.
// ----------------------------------------------------------------------------
module ssw_frame_seq #(
   parameter int DIGIT_COUNT = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   arm,
   input  ssw_pkg::seg_array_type arm_segments,
   input  logic                   step,
   input  ssw_pkg::cfg_type       cfg,
   output ssw_pkg::rsp_type       result
);
   import ssw_pkg::*;

   localparam logic [PIECE_W-1:0] P_DATA_START  = PIECE_W'(0);
   localparam logic [PIECE_W-1:0] P_DATA_CMD    = PIECE_W'(1);
   localparam logic [PIECE_W-1:0] P_DATA_STOP   = PIECE_W'(2);
   localparam logic [PIECE_W-1:0] P_ADDR_START  = PIECE_W'(3);
   localparam logic [PIECE_W-1:0] P_ADDR_CMD    = PIECE_W'(4);
   localparam logic [PIECE_W-1:0] P_DIGIT_FIRST = PIECE_W'(5);
   localparam logic [PIECE_W-1:0] P_ADDR_STOP   = PIECE_W'(5 + DIGIT_COUNT);
   localparam logic [PIECE_W-1:0] P_DISP_START  = PIECE_W'(6 + DIGIT_COUNT);
   localparam logic [PIECE_W-1:0] P_DISP_CMD    = PIECE_W'(7 + DIGIT_COUNT);
   localparam logic [PIECE_W-1:0] P_DISP_STOP   = PIECE_W'(8 + DIGIT_COUNT);
   localparam logic [PIECE_W:0]   PIECE_TOTAL   = (PIECE_W+1)'(9 + DIGIT_COUNT);

   logic                clock_pin_ff, clock_pin_in;
   logic                data_pin_ff, data_pin_in;
   logic                active_ff, active_in;
   logic [PIECE_W-1:0]  piece_ff, piece_in;
   logic [PHASE_W-1:0]  phase_ff, phase_in;
   logic [1:0]          sub_ff, sub_in;
   logic [SEG_W-1:0]    shift_ff, shift_in;
   seg_array_type       store_ff;

   logic [1:0]          kind;
   logic [PHASE_W-1:0]  last_phase;
   logic [SEG_W-1:0]    piece_byte;
   logic [PIECE_W-1:0]  digit_k;
   logic [SEG_W-1:0]    digit_byte;
   logic [PIECE_W:0]    piece_next;
   logic                done;

   always_comb begin
      if (piece_ff == P_DATA_START || piece_ff == P_ADDR_START ||
          piece_ff == P_DISP_START) begin
         kind = KIND_START;
      end else if (piece_ff == P_DATA_STOP || piece_ff == P_ADDR_STOP ||
                   piece_ff == P_DISP_STOP) begin
         kind = KIND_STOP;
      end else begin
         kind = KIND_BYTE;
      end
   end

   always_comb begin
      case (kind)
         KIND_START: last_phase = START_LAST;
         KIND_STOP:  last_phase = STOP_LAST;
         default:    last_phase = BYTE_LAST;
      endcase
   end

   // digits past the fourth send a blank byte
   always_comb begin
      digit_k = piece_ff - P_DIGIT_FIRST;
      if (digit_k < PIECE_W'(NUM_SEG)) begin
         digit_byte = store_ff[digit_k[1:0]];
      end else begin
         digit_byte = '0;
      end
      if (digit_k == PIECE_W'(1)) begin
         digit_byte = digit_byte & cfg.colon_mask;
      end
   end

   always_comb begin
      if (piece_ff == P_DATA_CMD) begin
         piece_byte = cfg.data_command;
      end else if (piece_ff == P_ADDR_CMD) begin
         piece_byte = cfg.address_command;
      end else if (piece_ff == P_DISP_CMD) begin
         piece_byte = cfg.display_command;
      end else if (piece_ff >= P_DIGIT_FIRST && piece_ff < P_ADDR_STOP) begin
         piece_byte = digit_byte;
      end else begin
         piece_byte = '0;
      end
   end

   always_comb begin
      clock_pin_in = clock_pin_ff;
      data_pin_in  = data_pin_ff;
      active_in    = active_ff;
      piece_in     = piece_ff;
      phase_in     = phase_ff;
      sub_in       = sub_ff;
      shift_in     = shift_ff;
      done         = 1'b0;
      piece_next   = {1'b0, piece_ff} + (PIECE_W+1)'(1);

      if (arm && !active_ff) begin
         active_in = 1'b1;
         piece_in  = '0;
         phase_in  = '0;
         sub_in    = '0;
      end else if (step && active_ff) begin
         case (kind)
            KIND_START: begin
               if (phase_ff == '0) data_pin_in = 1'b0;
            end
            KIND_STOP: begin
               if (phase_ff == PHASE_W'(0)) clock_pin_in = 1'b0;
               else if (phase_ff == PHASE_W'(2)) clock_pin_in = 1'b1;
               else if (phase_ff == PHASE_W'(3)) data_pin_in = 1'b1;
            end
            default: begin
               // slot: clock low, data bit, clock high
               case (sub_ff)
                  2'd0: begin
                     clock_pin_in = 1'b0;
                     if (phase_ff == '0) shift_in = piece_byte;
                  end
                  2'd1: begin
                     data_pin_in = shift_ff[0];
                     shift_in    = shift_ff >> 1;
                  end
                  default: clock_pin_in = 1'b1;
               endcase
            end
         endcase

         if (phase_ff >= last_phase) begin
            phase_in = '0;
            sub_in   = '0;
            if (piece_next >= PIECE_TOTAL) begin
               active_in = 1'b0;
               piece_in  = '0;
               done      = 1'b1;
            end else begin
               piece_in = piece_next[PIECE_W-1:0];
            end
         end else begin
            phase_in = phase_ff + PHASE_W'(1);
            sub_in   = (sub_ff == 2'd2) ? 2'd0 : sub_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_pin_ff <= 1'b1;
         data_pin_ff  <= 1'b1;
         active_ff    <= 1'b0;
         piece_ff     <= '0;
         phase_ff     <= '0;
         sub_ff       <= '0;
         shift_ff     <= '0;
      end else begin
         clock_pin_ff <= clock_pin_in;
         data_pin_ff  <= data_pin_in;
         active_ff    <= active_in;
         piece_ff     <= piece_in;
         phase_ff     <= phase_in;
         sub_ff       <= sub_in;
         shift_ff     <= shift_in;
      end
   end

   always_ff @(posedge clock) begin
      if (arm && !active_ff) begin
         store_ff <= arm_segments;
      end
   end

   assign result.clock_level = clock_pin_in;
   assign result.data_level  = data_pin_in;
   assign result.frame_done  = done;
   assign result.busy_res    = active_in;

endmodule

/* design/seven_seg_two_wire_writer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_seg_two_wire_writer_unit
// Drives a two-wire LED display controller one pin step per tick transaction.
// A write transaction latches four segment bytes and arms the frame (data
// command, address command plus digits, display command); it returns nothing,
// and is dropped if a frame is already running. Each tick transaction returns
// the clock and data pin levels, a done flag and a busy flag. One transaction
// is taken per clock cycle; a tick's response is registered and appears the
// cycle after acceptance. The single response register sets this rate: input
// is accepted whenever that register is empty or being drained.
// ----------------------------------------------------------------------------
module seven_seg_two_wire_writer_unit #(
   parameter int DIGIT_COUNT = 4
) (
   input  logic            clock,
   input  logic            reset,
   ssw_req_if.sink         req_chan,
   ssw_rsp_if.source       rsp_chan,
   ssw_csr_if.sink         csr_chan
);
   import ssw_pkg::*;

   cfg_type       cfg_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff;
   rsp_type       step_result;
   seg_array_type arm_segments;
   logic          req_accept;
   logic          tick_accept;
   logic          write_accept;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign tick_accept    = req_accept && (req_chan.opcode == OP_TICK);
   assign write_accept   = req_accept && (req_chan.opcode == OP_WRITE);

   assign arm_segments[0] = req_chan.segment_zero;
   assign arm_segments[1] = req_chan.segment_one;
   assign arm_segments[2] = req_chan.segment_two;
   assign arm_segments[3] = req_chan.segment_three;

   ssw_frame_seq #(
      .DIGIT_COUNT (DIGIT_COUNT)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .arm          (write_accept),
      .arm_segments (arm_segments),
      .step         (tick_accept),
      .cfg          (cfg_ff),
      .result       (step_result)
   );

   // register file
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.data_command    <= DATA_CMD_RST;
         cfg_ff.address_command <= ADDR_CMD_RST;
         cfg_ff.display_command <= DISPLAY_CMD_RST;
         cfg_ff.colon_mask      <= COLON_MASK_RST;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_DATA_CMD:    cfg_ff.data_command    <= csr_chan.data;
            CSR_ADDR_CMD:    cfg_ff.address_command <= csr_chan.data;
            CSR_DISPLAY_CMD: cfg_ff.display_command <= csr_chan.data;
            CSR_COLON_MASK:  cfg_ff.colon_mask      <= csr_chan.data;
            default: ;
         endcase
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (tick_accept) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tick_accept) begin
         rsp_ff <= step_result;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.clock_level = rsp_ff.clock_level;
   assign rsp_chan.data_level  = rsp_ff.data_level;
   assign rsp_chan.frame_done  = rsp_ff.frame_done;
   assign rsp_chan.busy_res    = rsp_ff.busy_res;

endmodule

/* design/ssw_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssw_port_checker
// Port-level checks for the display writer, bound to the top level.
// ----------------------------------------------------------------------------
module ssw_port_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_opcode,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic clock_level,
   input logic data_level,
   input logic frame_done,
   input logic busy_res
);
   import ssw_pkg::*;

   // a new response only follows an accepted tick transaction
   a_rsp_from_tick: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_opcode == OP_TICK))
      else $error("response without a tick transaction");

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && frame_done) |-> !busy_res)
      else $error("frame done while still busy");

   // bus is released high whenever no frame is running
   a_idle_pins_high: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !busy_res) |-> (clock_level && data_level))
      else $error("pins not idle high outside a frame");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(clock_level) &&
         $stable(data_level) && $stable(frame_done) && $stable(busy_res)))
      else $error("stalled response changed");

endmodule

bind seven_seg_two_wire_writer_unit ssw_port_checker u_ssw_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .req_opcode  (req_chan.opcode),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .clock_level (rsp_chan.clock_level),
   .data_level  (rsp_chan.data_level),
   .frame_done  (rsp_chan.frame_done),
   .busy_res    (rsp_chan.busy_res)
);
